// ----- design/olte_pkg.sv -----
`default_nettype none

package olte_pkg;

  // Default list depth
  localparam int unsigned DefaultCapacity = 64;

  // Entry count after reset; the first ResetCount entries hold 1..ResetCount
  localparam int unsigned ResetCount = 5;

  // Command codes
  typedef enum logic [2:0] {
    FN_APPEND  = 3'd0,
    FN_INSERT  = 3'd1,
    FN_DELETE  = 3'd2,
    FN_WRITE   = 3'd3,
    FN_REPLACE = 3'd4,
    FN_READ    = 3'd5,
    FN_FIND    = 3'd6,
    FN_UNUSED  = 3'd7
  } olte_func_e;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_PAST_END  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } olte_status_e;

  // One command request
  typedef struct packed {
    logic [2:0]         func;
    logic [6:0]         position;
    logic signed [31:0] new_value;
    logic signed [31:0] old_value;
  } olte_req_t;

  // One command response
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_data;
    logic [6:0]         found_position;
    logic [6:0]         entry_count;
  } olte_rsp_t;

endpackage

`default_nettype wire

// ----- design/ordered_list_table_engine_unit.sv -----
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit entries held in a single-port-write,
// single-port-read memory, walked by one small sequencer. After reset the unit
// loads the preset entries 1..5 and is not ready meanwhile. One request is taken
// at a time. Append, write, every rejected request and the unused code walk no
// entries. Read walks one entry, insert walks count - position + 1, delete
// count - position and replace count. Find stops at the first match. The walk
// moves one entry per cycle, bounded by the one read and one write port of the
// entry memory. The response sits in an output register, so a new request is
// taken while it waits; the next response is held back until the old one is taken.
module ordered_list_table_engine_unit #(
  parameter int unsigned CAPACITY = olte_pkg::DefaultCapacity
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  olte_pkg::olte_req_t   in_req_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output olte_pkg::olte_rsp_t   out_rsp_o
);
  import olte_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((CW > 7) ? CW : 7) + 1;
  localparam logic [PW-1:0] CapW = PW'(CAPACITY);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [2:0] InitLast = 3'(ResetCount - 1);

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_WALK   = 5'b00100,
    S_FINISH = 5'b01000,
    S_SPARE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Control registers
  logic [CW-1:0] count_q, count_d;
  logic [2:0]    init_q, init_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          down_q, down_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic          any_q, any_d;
  logic          hit_q, hit_d;
  logic          out_valid_q, out_valid_d;

  // Request and result registers
  logic [2:0]         func_q, func_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic signed [31:0] nv_q, nv_d;
  logic signed [31:0] ov_q, ov_d;
  logic [2:0]         status_q, status_d;
  logic [CW-1:0]      found_q, found_d;
  logic signed [31:0] res_data_q, res_data_d;
  olte_rsp_t          out_q, out_d;

  // Entry memory
  logic signed [31:0] mem_q [CAPACITY];
  logic signed [31:0] rdata_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;

  // Request checks
  logic [PW-1:0] posx, cntx;
  logic          range_bad, past_cnt, past_cnt1, is_full;
  logic [CW-1:0] pos_c;
  logic          fin_go;
  logic [CW-1:0] next_count;

  assign posx      = PW'(in_req_i.position);
  assign cntx      = PW'(count_q);
  assign range_bad = (in_req_i.position == 7'd0) || (posx > CapW);
  assign past_cnt  = posx > cntx;
  assign past_cnt1 = posx > (cntx + PW'(1));
  assign is_full   = count_q == CapC;
  assign pos_c     = CW'(in_req_i.position);
  assign fin_go    = !out_valid_q || out_ready_i;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Sequence the walk and the result
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    init_d      = init_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    down_d      = down_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    any_d       = any_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    func_d      = func_q;
    pos_d       = pos_q;
    nv_d        = nv_q;
    ov_d        = ov_q;
    status_d    = status_q;
    found_d     = found_q;
    res_data_d  = res_data_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = nv_q;
    next_count  = count_q;

    // Drop the response once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        // Load the preset entries
        mem_we    = 1'b1;
        mem_waddr = AW'(init_q);
        mem_wdata = 32'(init_q) + 32'sd1;
        init_d    = init_q + 3'd1;
        if (init_q == InitLast) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          func_d     = in_req_i.func;
          pos_d      = pos_c;
          nv_d       = in_req_i.new_value;
          ov_d       = in_req_i.old_value;
          status_d   = ST_OK;
          found_d    = '0;
          res_data_d = '0;
          any_d      = 1'b0;
          hit_d      = 1'b0;
          pend_d     = 1'b0;
          down_d     = 1'b0;
          idx_d      = '0;
          rem_d      = count_q;
          state_d    = S_FINISH;
          unique case (in_req_i.func)
            FN_APPEND: begin
              if (is_full) status_d = ST_FULL;
            end
            FN_INSERT: begin
              if (range_bad) status_d = ST_RANGE;
              else if (past_cnt1) status_d = ST_PAST_END;
              else if (is_full) status_d = ST_FULL;
              else begin
                idx_d   = AW'(count_q - CW'(1));
                rem_d   = CW'(count_q - pos_c + CW'(1));
                down_d  = 1'b1;
                state_d = S_WALK;
              end
            end
            FN_DELETE: begin
              if (range_bad) status_d = ST_RANGE;
              else if (past_cnt) status_d = ST_PAST_END;
              else begin
                idx_d   = AW'(pos_c);
                rem_d   = CW'(count_q - pos_c);
                state_d = S_WALK;
              end
            end
            FN_WRITE: begin
              if (range_bad) status_d = ST_RANGE;
              else if (past_cnt) status_d = ST_PAST_END;
            end
            FN_REPLACE: begin
              state_d = S_WALK;
            end
            FN_READ: begin
              if (range_bad) status_d = ST_RANGE;
              else if (past_cnt) status_d = ST_PAST_END;
              else begin
                idx_d   = AW'(pos_c - CW'(1));
                rem_d   = CW'(1);
                state_d = S_WALK;
              end
            end
            FN_FIND: begin
              state_d = S_WALK;
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        // Handle the entry read last cycle
        if (pend_q) begin
          unique case (func_q)
            FN_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pend_addr_q + AW'(1);
              mem_wdata = rdata_q;
            end
            FN_DELETE: begin
              mem_we    = 1'b1;
              mem_waddr = pend_addr_q - AW'(1);
              mem_wdata = rdata_q;
            end
            FN_REPLACE: begin
              if (rdata_q == ov_q) begin
                mem_we    = 1'b1;
                mem_waddr = pend_addr_q;
                mem_wdata = nv_q;
                any_d     = 1'b1;
              end
            end
            FN_READ: begin
              res_data_d = rdata_q;
            end
            FN_FIND: begin
              if (rdata_q == nv_q) begin
                hit_d   = 1'b1;
                found_d = CW'(pend_addr_q) + CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
        // Issue the next read or wind up
        if (func_q == FN_FIND && pend_q && rdata_q == nv_q) begin
          pend_d  = 1'b0;
          state_d = S_FINISH;
        end else if (rem_q != '0) begin
          pend_d      = 1'b1;
          pend_addr_d = idx_q;
          idx_d       = down_q ? idx_q - AW'(1) : idx_q + AW'(1);
          rem_d       = rem_q - CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (fin_go) begin
          status_d = status_q;
          if (func_q == FN_REPLACE && !any_q) status_d = ST_NOT_FOUND;
          if (func_q == FN_FIND && !hit_q) status_d = ST_NOT_FOUND;
          // Commit the final write and the count
          if (status_q == ST_OK) begin
            unique case (func_q)
              FN_APPEND: begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(count_q);
                next_count = count_q + CW'(1);
              end
              FN_INSERT: begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(pos_q - CW'(1));
                next_count = count_q + CW'(1);
              end
              FN_DELETE: begin
                next_count = count_q - CW'(1);
              end
              FN_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(pos_q - CW'(1));
              end
              default: begin
              end
            endcase
          end
          count_d              = next_count;
          out_d.status         = status_d;
          out_d.read_data      = (func_q == FN_READ && status_q == ST_OK) ? res_data_q : '0;
          out_d.found_position = hit_q ? 7'(found_q) : 7'd0;
          out_d.entry_count    = 7'(next_count);
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      count_q     <= CW'(ResetCount);
      init_q      <= '0;
      idx_q       <= '0;
      rem_q       <= '0;
      down_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      any_q       <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      init_q      <= init_d;
      idx_q       <= idx_d;
      rem_q       <= rem_d;
      down_q      <= down_d;
      pend_q      <= pend_d;
      pend_addr_q <= pend_addr_d;
      any_q       <= any_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold request and result payload
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    pos_q      <= pos_d;
    nv_q       <= nv_d;
    ov_q       <= ov_d;
    status_q   <= status_d;
    found_q    <= found_d;
    res_data_q <= res_data_d;
    out_q      <= out_d;
  end

  // Write and read the entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[idx_q];
  end

endmodule

`default_nettype wire
